/* hdl/nlcm_pkg.sv */
// Shared types, constants and calendar tables for the no-leap minute converter.
package nlcm_pkg;

    // Conversion direction carried in the request's tuser.
    typedef enum logic {
        CMD_TO_COUNT  = 1'b0,
        CMD_TO_FIELDS = 1'b1
    } cmd_t;

    // Register stages: input register, four datapath stages, result register.
    localparam int NUM_STAGES = 6;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    localparam logic [13:0] EPOCH_YEAR   = 14'd1970;
    localparam logic [13:0] LAST_YEAR    = 14'd9999;
    localparam logic [19:0] MIN_PER_YEAR = 20'd525600;
    localparam logic [10:0] MIN_PER_DAY  = 11'd1440;
    localparam logic [5:0]  MIN_PER_HOUR = 6'd60;
    localparam logic [4:0]  HOUR_PER_DAY = 5'd24;
    localparam logic [4:0]  LAST_HOUR    = 5'd23;
    localparam logic [5:0]  LAST_MINUTE  = 6'd59;
    localparam logic [3:0]  LAST_MONTH   = 4'd12;

    // Reciprocals for the constant divisions.
    // Minutes per year is 32 * 16425; the estimate is floor(2^40 / 16425) and
    // may come out one low, which a later stage corrects.
    localparam logic [25:0] RECIP_YEAR = 26'd66941347;
    localparam int          YEAR_SHIFT = 40;
    // Minutes to hours: (x / 4) / 15 with ceil(2^26 / 15), exact below 2^18.
    localparam logic [22:0] RECIP_HOUR = 23'd4473925;
    localparam int          HOUR_SHIFT = 26;
    // Minutes to days: (x / 32) / 45 with ceil(2^25 / 45), exact below 2^15.
    localparam logic [19:0] RECIP_DAY  = 20'd745655;
    localparam int          DAY_SHIFT  = 25;

    // Stage load strobes and the direction of the item leaving the last
    // datapath stage.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        cmd_t                  cmd;
    } ctl_t;

    // Calendar fields of a converted count.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } fields_t;

    // Day of year (from 0) on which a month starts; months outside 1..12 give 0.
    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] start;
        case (month)
            4'd1:    start = 9'd0;
            4'd2:    start = 9'd31;
            4'd3:    start = 9'd59;
            4'd4:    start = 9'd90;
            4'd5:    start = 9'd120;
            4'd6:    start = 9'd151;
            4'd7:    start = 9'd181;
            4'd8:    start = 9'd212;
            4'd9:    start = 9'd243;
            4'd10:   start = 9'd273;
            4'd11:   start = 9'd304;
            4'd12:   start = 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

    // Length of a month; months outside 1..12 give 0 so that no day passes.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* hdl/no_leap_calendar_minute_converter_top.sv */
// Top level of the no-leap calendar minute converter.
// Each request passes through six register stages (input register, four datapath
// stages, result register), each holding one request; throughput is one request
// per cycle while the result is not stalled.
// A stalled result only stops the unbroken run of full stages directly behind it.
// Reset (aresetn low, synchronous) empties every stage; data registers are not reset.
module no_leap_calendar_minute_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] count_minutes, [45:32] year, [49:46] month, [54:50] day,
    // [59:55] hour, [65:60] minute, [71:66] zero
    input  logic [71:0] s_tdata,
    // [0] cmd
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] out_count, [45:32] out_year, [49:46] out_month, [54:50] out_day,
    // [59:55] out_hour, [65:60] out_minute, [71:66] zero
    output logic [71:0] m_tdata,
    // [0] range_error
    output logic [0:0]  m_tuser
);

    nlcm_pkg::ctl_t    ctl;
    logic [31:0]       in_count_reg;
    logic [13:0]       in_year_reg;
    logic [3:0]        in_month_reg;
    logic [4:0]        in_day_reg;
    logic [4:0]        in_hour_reg;
    logic [5:0]        in_minute_reg;

    logic [31:0]       tc_count;
    logic              tc_error;
    logic [31:0]       tf_count;
    nlcm_pkg::fields_t tf_fields;

    logic [31:0]       out_count_next;
    nlcm_pkg::fields_t out_fields_next;
    logic              out_error_next;
    logic [31:0]       out_count_reg;
    nlcm_pkg::fields_t out_fields_reg;
    logic              out_error_reg;

    nlcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (nlcm_pkg::cmd_t'(s_tuser[0])),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .ctl      (ctl)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            in_count_reg  <= s_tdata[31:0];
            in_year_reg   <= s_tdata[45:32];
            in_month_reg  <= s_tdata[49:46];
            in_day_reg    <= s_tdata[54:50];
            in_hour_reg   <= s_tdata[59:55];
            in_minute_reg <= s_tdata[65:60];
        end
    end

    nlcm_to_count u_to_count (
        .aclk        (aclk),
        .ctl         (ctl),
        .year        (in_year_reg),
        .month       (in_month_reg),
        .day         (in_day_reg),
        .hour        (in_hour_reg),
        .minute      (in_minute_reg),
        .count       (tc_count),
        .range_error (tc_error)
    );

    nlcm_to_fields u_to_fields (
        .aclk          (aclk),
        .ctl           (ctl),
        .count_minutes (in_count_reg),
        .count_echo    (tf_count),
        .fields        (tf_fields)
    );

    // Pick the result of the requested direction.
    always_comb begin
        case (ctl.cmd)
            nlcm_pkg::CMD_TO_FIELDS: begin
                out_count_next  = tf_count;
                out_fields_next = tf_fields;
                out_error_next  = 1'b0;
            end
            default: begin
                out_count_next  = tc_count;
                out_fields_next = '0;
                out_error_next  = tc_error;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (ctl.load[nlcm_pkg::LAST_STAGE]) begin
            out_count_reg  <= out_count_next;
            out_fields_reg <= out_fields_next;
            out_error_reg  <= out_error_next;
        end
    end

    assign m_tdata = {6'd0, out_fields_reg.minute, out_fields_reg.hour, out_fields_reg.day,
                      out_fields_reg.month, out_fields_reg.year, out_count_reg};
    assign m_tuser = out_error_reg;

endmodule

/* hdl/nlcm_ctrl.sv */
// Stage valid tracking, per-stage flow control and direction tracking.
module nlcm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  nlcm_pkg::cmd_t       s_cmd,
    output logic                 s_tready,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output nlcm_pkg::ctl_t       ctl
);

    logic [nlcm_pkg::NUM_STAGES-1:0] valid_reg;
    logic [nlcm_pkg::NUM_STAGES-1:0] valid_next;
    logic [nlcm_pkg::NUM_STAGES-1:0] ready;
    nlcm_pkg::cmd_t                  cmd_reg [nlcm_pkg::LAST_STAGE];

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        ready[nlcm_pkg::LAST_STAGE] = !valid_reg[nlcm_pkg::LAST_STAGE] || m_tready;
        for (int i = nlcm_pkg::LAST_STAGE - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    // Valid bits follow their requests down the pipeline.
    always_comb begin
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < nlcm_pkg::NUM_STAGES; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // The direction travels with each request up to the result mux.
    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            cmd_reg[0] <= s_cmd;
        end
        for (int i = 1; i < nlcm_pkg::LAST_STAGE; i++) begin
            if (ready[i]) begin
                cmd_reg[i] <= cmd_reg[i-1];
            end
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[nlcm_pkg::LAST_STAGE];
    assign ctl.load = ready;
    assign ctl.cmd  = cmd_reg[nlcm_pkg::LAST_STAGE-1];

endmodule

/* hdl/nlcm_to_count.sv */
// Calendar fields to minute count: field checks and the weighted sum.
module nlcm_to_count (
    input  logic           aclk,
    input  nlcm_pkg::ctl_t ctl,
    input  logic [13:0]    year,
    input  logic [3:0]     month,
    input  logic [4:0]     day,
    input  logic [4:0]     hour,
    input  logic [5:0]     minute,
    output logic [31:0]    count,
    output logic           range_error
);

    logic        s1_ok_reg;
    logic [12:0] s1_yoff_reg;
    logic [8:0]  s1_dayidx_reg;
    logic [10:0] s1_hm_reg;
    logic        s1_ok_next;
    logic [13:0] yoff_full;

    logic        s2_ok_reg;
    logic [31:0] s2_ym_reg;
    logic [19:0] s2_dm_reg;

    logic        s3_ok_reg;
    logic [31:0] s3_count_reg;

    logic        s4_ok_reg;
    logic [31:0] s4_count_reg;

    // Stage 1: range checks, year offset, day of year and minute of day.
    always_comb begin
        s1_ok_next = (year >= nlcm_pkg::EPOCH_YEAR) && (year <= nlcm_pkg::LAST_YEAR)
                  && (month != 4'd0) && (month <= nlcm_pkg::LAST_MONTH)
                  && (hour <= nlcm_pkg::LAST_HOUR) && (minute <= nlcm_pkg::LAST_MINUTE)
                  && (day != 5'd0) && (day <= nlcm_pkg::month_len(month));
        yoff_full  = year - nlcm_pkg::EPOCH_YEAR;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            s1_ok_reg     <= s1_ok_next;
            s1_yoff_reg   <= yoff_full[12:0];
            s1_dayidx_reg <= nlcm_pkg::month_start(month) + 9'(day) - 9'd1;
            s1_hm_reg     <= 11'(hour) * 11'(nlcm_pkg::MIN_PER_HOUR) + 11'(minute);
        end
    end

    // Stage 2: scale years and days to minutes.
    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            s2_ok_reg <= s1_ok_reg;
            s2_ym_reg <= 32'(s1_yoff_reg) * 32'(nlcm_pkg::MIN_PER_YEAR);
            s2_dm_reg <= 20'(s1_dayidx_reg) * 20'(nlcm_pkg::MIN_PER_DAY) + 20'(s1_hm_reg);
        end
    end

    // Stage 3: final sum; an invalid request reports a zero count.
    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            s3_ok_reg    <= s2_ok_reg;
            s3_count_reg <= s2_ok_reg ? (s2_ym_reg + 32'(s2_dm_reg)) : 32'd0;
        end
    end

    // Stage 4: hold the result level with the other direction.
    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            s4_ok_reg    <= s3_ok_reg;
            s4_count_reg <= s3_count_reg;
        end
    end

    assign count       = s4_count_reg;
    assign range_error = !s4_ok_reg;

endmodule

/* hdl/nlcm_to_fields.sv */
// Minute count to calendar fields: reciprocal divisions and month lookup.
module nlcm_to_fields (
    input  logic              aclk,
    input  nlcm_pkg::ctl_t    ctl,
    input  logic [31:0]       count_minutes,
    output logic [31:0]       count_echo,
    output nlcm_pkg::fields_t fields
);

    logic [52:0] year_prod;
    logic [31:0] s1_count_reg;
    logic [12:0] s1_years_reg;

    logic [31:0] year_mins;
    logic [31:0] rem_wide;
    logic [31:0] s2_count_reg;
    logic [12:0] s2_years_reg;
    logic [20:0] s2_rem_reg;

    logic [31:0] s3_count_reg;
    logic [12:0] s3_years_reg;
    logic [19:0] s3_rem_reg;

    logic [40:0] hour_prod;
    logic [34:0] day_prod;
    logic [31:0] s4_count_reg;
    logic [12:0] s4_years_reg;
    logic [19:0] s4_rem_reg;
    logic [13:0] s4_hoy_reg;
    logic [8:0]  s4_doy_reg;

    logic [19:0] minute_wide;
    logic [13:0] hour_wide;
    logic [3:0]  month_cnt;
    logic [3:0]  month_val;
    logic [8:0]  day_wide;

    // Stage 1: year estimate by reciprocal multiply.
    assign year_prod = 53'(count_minutes[31:5]) * 53'(nlcm_pkg::RECIP_YEAR);

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            s1_count_reg <= count_minutes;
            s1_years_reg <= year_prod[nlcm_pkg::YEAR_SHIFT +: 13];
        end
    end

    // Stage 2: minutes left over after the estimated years.
    always_comb begin
        year_mins = 32'(s1_years_reg) * 32'(nlcm_pkg::MIN_PER_YEAR);
        rem_wide  = s1_count_reg - year_mins;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            s2_count_reg <= s1_count_reg;
            s2_years_reg <= s1_years_reg;
            s2_rem_reg   <= rem_wide[20:0];
        end
    end

    // Stage 3: correct an estimate that came out one year low.
    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            s3_count_reg <= s2_count_reg;
            if (s2_rem_reg >= 21'(nlcm_pkg::MIN_PER_YEAR)) begin
                s3_years_reg <= s2_years_reg + 13'd1;
                s3_rem_reg   <= 20'(s2_rem_reg - 21'(nlcm_pkg::MIN_PER_YEAR));
            end else begin
                s3_years_reg <= s2_years_reg;
                s3_rem_reg   <= s2_rem_reg[19:0];
            end
        end
    end

    // Stage 4: hour of year and day of year by reciprocal multiply.
    assign hour_prod = 41'(s3_rem_reg[19:2]) * 41'(nlcm_pkg::RECIP_HOUR);
    assign day_prod  = 35'(s3_rem_reg[19:5]) * 35'(nlcm_pkg::RECIP_DAY);

    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            s4_count_reg <= s3_count_reg;
            s4_years_reg <= s3_years_reg;
            s4_rem_reg   <= s3_rem_reg;
            s4_hoy_reg   <= hour_prod[nlcm_pkg::HOUR_SHIFT +: 14];
            s4_doy_reg   <= day_prod[nlcm_pkg::DAY_SHIFT +: 9];
        end
    end

    // Remainders, and the month found by counting the month starts passed.
    always_comb begin
        minute_wide = s4_rem_reg - 20'(s4_hoy_reg) * 20'(nlcm_pkg::MIN_PER_HOUR);
        hour_wide   = s4_hoy_reg - 14'(s4_doy_reg) * 14'(nlcm_pkg::HOUR_PER_DAY);
        month_cnt   = 4'd0;
        for (int m = 2; m <= 12; m++) begin
            if (s4_doy_reg >= nlcm_pkg::month_start(4'(m))) begin
                month_cnt = month_cnt + 4'd1;
            end
        end
        month_val   = month_cnt + 4'd1;
        day_wide    = s4_doy_reg - nlcm_pkg::month_start(month_val) + 9'd1;
    end

    assign count_echo    = s4_count_reg;
    assign fields.year   = 14'(s4_years_reg) + nlcm_pkg::EPOCH_YEAR;
    assign fields.month  = month_val;
    assign fields.day    = day_wide[4:0];
    assign fields.hour   = hour_wide[4:0];
    assign fields.minute = minute_wide[5:0];

endmodule

/* hdl/nlcm_checker.sv */
// Port-level checks for the converter, bound to the top level.
module nlcm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its data and flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // A flagged field error always reports a zero count and zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 72'd0)
        else $error("range error with nonzero payload");

    // Decoded calendar fields are always in range and never flagged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[45:32] != 14'd0) |->
            !m_tuser[0] && (m_tdata[49:46] != 4'd0) && (m_tdata[49:46] <= 4'd12)
            && (m_tdata[54:50] != 5'd0) && (m_tdata[59:55] <= 5'd23)
            && (m_tdata[65:60] <= 6'd59))
        else $error("decoded calendar field out of range");

    // Reset empties the result stage.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind no_leap_calendar_minute_converter_top nlcm_checker u_nlcm_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the no-leap calendar minute converter.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned FIRST_YEAR     = 1970;
    localparam int unsigned FINAL_YEAR     = 9999;
    localparam int unsigned MINS_PER_HOUR  = 60;
    localparam int unsigned MINS_PER_DAY   = 1440;
    localparam int unsigned MINS_PER_YEAR  = 525600;
    localparam int unsigned DAYS_TO_MARCH  = 59;
    localparam int unsigned MAX_COUNT      = 32'd4220567999;
    localparam int          NUM_RANDOM     = 850;
    localparam int          MAX_WAIT       = 6;
    localparam int          PIPE_LATENCY   = 5;
    localparam int          WATCHDOG_LIMIT = 1000;

    // One conversion request; the struct after it holds the result it should produce.
    typedef struct {
        nlcm_pkg::cmd_t cmd;
        logic [31:0]    count;
        logic [13:0]    year;
        logic [3:0]     month;
        logic [4:0]     day;
        logic [4:0]     hour;
        logic [5:0]     minute;
        bit             wait_empty;
    } conv_req_t;

    typedef struct {
        logic [31:0] count;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        range_error;
    } conv_rsp_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;

    int unsigned days_in_month [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    conv_req_t pending_requests [$];
    conv_rsp_t expected_results [$];

    conv_req_t cur_req;
    bit        have_req    = 1'b0;
    int        req_gap     = 0;
    int        ready_stall = 0;
    logic      req_taken   = 1'b0;
    logic      rsp_taken   = 1'b0;
    int        n_requests  = 0;
    int        n_responses = 0;
    int        n_total     = 0;
    int        n_errors    = 0;
    int        idle_cycles = 0;

    no_leap_calendar_minute_converter_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Expected result of one request in a calendar without leap years.
    function automatic conv_rsp_t calendar_convert(input conv_req_t rq);
        conv_rsp_t   rs;
        int unsigned yr, mo, dy, hr, mn;
        int unsigned from_march, first_day;
        int unsigned rem, hrs_in_year, yday, shifted, t;
        bit          ok;
        rs = '{default: '0};
        if (rq.cmd == nlcm_pkg::CMD_TO_COUNT) begin
            yr = rq.year;
            mo = rq.month;
            dy = rq.day;
            hr = rq.hour;
            mn = rq.minute;
            ok = yr >= FIRST_YEAR && yr <= FINAL_YEAR && mo >= 1 && mo <= 12
                 && hr <= 23 && mn <= 59;
            if (ok)
                ok = dy >= 1 && dy <= days_in_month[mo];
            if (ok) begin
                // Month offset counted from March, then rotated back to January.
                from_march = (mo > 2) ? mo - 3 : mo + 9;
                first_day  = ((153 * from_march + 2) / 5 + DAYS_TO_MARCH) % 365;
                rs.count   = (yr - FIRST_YEAR) * MINS_PER_YEAR
                           + (first_day + dy - 1) * MINS_PER_DAY
                           + hr * MINS_PER_HOUR + mn;
            end else begin
                rs.range_error = 1'b1;
            end
        end else begin
            rem          = rq.count % MINS_PER_YEAR;
            hrs_in_year  = rem / MINS_PER_HOUR;
            yday         = hrs_in_year / 24;
            shifted      = (yday >= DAYS_TO_MARCH) ? yday - DAYS_TO_MARCH
                                                   : yday + 306;
            t            = (5 * shifted + 2) / 153;
            rs.count     = rq.count;
            rs.year      = 14'(rq.count / MINS_PER_YEAR + FIRST_YEAR);
            rs.month     = 4'((t < 10) ? t + 3 : t - 9);
            rs.day       = 5'(shifted - (153 * t + 2) / 5 + 1);
            rs.hour      = 5'(hrs_in_year % 24);
            rs.minute    = 6'(rem % MINS_PER_HOUR);
        end
        return rs;
    endfunction

    // Calendar request; the unused count carries random bits.
    function automatic conv_req_t cal_request(input int unsigned yr, input int unsigned mo,
                                              input int unsigned dy, input int unsigned hr,
                                              input int unsigned mn);
        conv_req_t rq;
        rq.cmd        = nlcm_pkg::CMD_TO_COUNT;
        rq.count      = $urandom;
        rq.year       = 14'(yr);
        rq.month      = 4'(mo);
        rq.day        = 5'(dy);
        rq.hour       = 5'(hr);
        rq.minute     = 6'(mn);
        rq.wait_empty = 1'b0;
        return rq;
    endfunction

    // Count request; the unused calendar fields carry random bits.
    function automatic conv_req_t count_request(input int unsigned cnt);
        conv_req_t rq;
        rq.cmd        = nlcm_pkg::CMD_TO_FIELDS;
        rq.count      = cnt;
        rq.year       = 14'($urandom);
        rq.month      = 4'($urandom);
        rq.day        = 5'($urandom);
        rq.hour       = 5'($urandom);
        rq.minute     = 6'($urandom);
        rq.wait_empty = 1'b0;
        return rq;
    endfunction

    // The request as it stands on the bus at the handshake.
    function automatic conv_req_t cur_req_from_bus();
        conv_req_t rq;
        rq.cmd        = nlcm_pkg::cmd_t'(s_tuser[0]);
        rq.count      = s_tdata[31:0];
        rq.year       = s_tdata[45:32];
        rq.month      = s_tdata[49:46];
        rq.day        = s_tdata[54:50];
        rq.hour       = s_tdata[59:55];
        rq.minute     = s_tdata[65:60];
        rq.wait_empty = 1'b0;
        return rq;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Request driver: present queued requests with random gaps.
    always @(negedge aclk) begin : drive_requests
        logic next_valid;
        next_valid = s_tvalid && !req_taken;
        if (aresetn && !next_valid) begin
            if (!have_req && pending_requests.size() != 0) begin
                cur_req  = pending_requests.pop_front();
                have_req = 1'b1;
                req_gap  = (n_requests % 200 < 40) ? 0 : $urandom_range(0, MAX_WAIT);
            end
            // A marked request holds off until the pipeline has drained.
            if (have_req && !(cur_req.wait_empty && expected_results.size() != 0)) begin
                if (req_gap != 0) begin
                    req_gap--;
                end else begin
                    s_tdata    <= {6'd0, cur_req.minute, cur_req.hour, cur_req.day,
                                   cur_req.month, cur_req.year, cur_req.count};
                    s_tuser    <= cur_req.cmd;
                    next_valid = 1'b1;
                    have_req   = 1'b0;
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // Result side back-pressure with random stalls.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rsp_taken)
                ready_stall = (n_responses % 200 < 40) ? 0 : $urandom_range(0, MAX_WAIT);
            if (ready_stall != 0) begin
                ready_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end else begin
            m_tready <= 1'b0;
        end
    end

    // Handshake monitor: predict on accepted requests, check accepted results.
    always @(posedge aclk) begin : monitor
        conv_rsp_t want;
        logic      req_hs;
        logic      rsp_hs;
        req_hs = aresetn && s_tvalid && s_tready;
        rsp_hs = aresetn && m_tvalid && m_tready;
        req_taken <= req_hs;
        rsp_taken <= rsp_hs;
        idle_cycles <= (req_hs || rsp_hs) ? 0 : idle_cycles + 1;
        if (req_hs) begin
            expected_results.push_back(calendar_convert(cur_req_from_bus()));
            n_requests++;
        end
        if (rsp_hs) begin
            n_responses++;
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: count %0d", m_tdata[31:0]);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("out_count", want.count, m_tdata[31:0]);
                check_field("out_year", want.year, m_tdata[45:32]);
                check_field("out_month", want.month, m_tdata[49:46]);
                check_field("out_day", want.day, m_tdata[54:50]);
                check_field("out_hour", want.hour, m_tdata[59:55]);
                check_field("out_minute", want.minute, m_tdata[65:60]);
                check_field("range_error", want.range_error, m_tuser[0]);
            end
        end
    end

    initial begin : stimulus
        conv_req_t   rq;
        int unsigned kind;
        int unsigned mo;
        int unsigned base;
        bit          timed_out;
        timed_out = 1'b0;

        // Directed requests: count extremes, the February/March seam, year ends,
        // and every kind of invalid calendar field.
        pending_requests.push_back(count_request(0));
        pending_requests.push_back(count_request(DAYS_TO_MARCH * MINS_PER_DAY - 1));
        pending_requests.push_back(count_request(DAYS_TO_MARCH * MINS_PER_DAY));
        pending_requests.push_back(count_request(MINS_PER_YEAR - 1));
        pending_requests.push_back(count_request(MINS_PER_YEAR));
        pending_requests.push_back(count_request(MAX_COUNT));
        pending_requests.push_back(count_request(MAX_COUNT + 1));
        pending_requests.push_back(count_request(32'hFFFF_FFFF));
        pending_requests.push_back(cal_request(1970, 1, 1, 0, 0));
        pending_requests.push_back(cal_request(9999, 12, 31, 23, 59));
        pending_requests.push_back(cal_request(2001, 2, 28, 12, 30));
        pending_requests.push_back(cal_request(2001, 2, 29, 0, 0));
        pending_requests.push_back(cal_request(2001, 3, 1, 0, 0));
        pending_requests.push_back(cal_request(2001, 4, 30, 7, 7));
        pending_requests.push_back(cal_request(2001, 4, 31, 7, 7));
        pending_requests.push_back(cal_request(2001, 0, 1, 0, 0));
        pending_requests.push_back(cal_request(2001, 13, 1, 0, 0));
        pending_requests.push_back(cal_request(2001, 15, 1, 0, 0));
        pending_requests.push_back(cal_request(2001, 1, 0, 0, 0));
        pending_requests.push_back(cal_request(2001, 1, 31, 24, 0));
        pending_requests.push_back(cal_request(2001, 1, 31, 31, 0));
        pending_requests.push_back(cal_request(2001, 1, 1, 0, 60));
        pending_requests.push_back(cal_request(2001, 1, 1, 0, 63));
        pending_requests.push_back(cal_request(1969, 12, 31, 23, 59));
        pending_requests.push_back(cal_request(10000, 1, 1, 0, 0));
        pending_requests.push_back(cal_request(0, 1, 1, 0, 0));
        pending_requests.push_back(cal_request(16383, 15, 31, 31, 63));

        // Random requests, mostly valid calendars and in-range counts.
        for (int i = 0; i < NUM_RANDOM; i++) begin
            kind = $urandom_range(0, 99);
            mo   = $urandom_range(1, 12);
            rq   = cal_request($urandom_range(FIRST_YEAR, FINAL_YEAR), mo,
                               $urandom_range(1, days_in_month[mo]),
                               $urandom_range(0, 23), $urandom_range(0, 59));
            if (kind >= 35 && kind < 50) begin
                // Break one field with a value from its whole range.
                case ($urandom_range(0, 4))
                    0:       rq.year   = 14'($urandom);
                    1:       rq.month  = 4'($urandom);
                    2:       rq.day    = 5'($urandom);
                    3:       rq.hour   = 5'($urandom);
                    default: rq.minute = 6'($urandom);
                endcase
            end else if (kind >= 50 && kind < 60) begin
                rq = cal_request($urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (kind >= 60 && kind < 85) begin
                rq = count_request($urandom_range(0, MAX_COUNT));
            end else if (kind >= 85 && kind < 93) begin
                // Near a year boundary or the start of March.
                base = $urandom_range(0, 8171) * MINS_PER_YEAR
                     + ($urandom_range(0, 1) ? DAYS_TO_MARCH * MINS_PER_DAY : 0);
                rq = count_request(base + $urandom_range(0, 2 * MINS_PER_DAY) - MINS_PER_DAY);
            end else if (kind >= 93) begin
                rq = count_request($urandom);
            end
            rq.wait_empty = (i % 300 == 150);
            pending_requests.push_back(rq);
        end
        n_total = pending_requests.size();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!timed_out && !(n_requests == n_total && expected_results.size() == 0)) begin
            @(posedge aclk);
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end

        if (timed_out) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
        end else begin
            // Let any stray result show up before the verdict.
            repeat (4 * PIPE_LATENCY) @(posedge aclk);
            if (expected_results.size() != 0) begin
                $error("%0d expected results never arrived", expected_results.size());
                n_errors++;
            end
            if (n_errors == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end

endmodule
